// File: hw/rtl/tpp_pkg.sv
package tpp_pkg;

  localparam int CoordW = 16;
  localparam int FocalW = 12;
  localparam int CfgW = 16;
  localparam int IndexW = 2;
  localparam int ProdW = CoordW + FocalW + 1;
  localparam int DepthW = CoordW + 2;
  localparam int NumW = CoordW + FocalW - 1;
  localparam int DenW = CoordW + 1;
  localparam int QuotW = NumW + 1;
  localparam int SumW = QuotW + 1;
  localparam int PipeDepth = NumW + 3;

  localparam logic [IndexW-1:0] REG_CAMERA_X = 2'd0;
  localparam logic [IndexW-1:0] REG_CAMERA_Y = 2'd1;
  localparam logic [IndexW-1:0] REG_CAMERA_Z = 2'd2;
  localparam logic [IndexW-1:0] REG_FOCAL = 2'd3;

  localparam logic [FocalW-1:0] FOCAL_RESET = 12'd900;

  typedef struct packed {
    logic signed [CoordW-1:0] camera_x;
    logic signed [CoordW-1:0] camera_y;
    logic signed [CoordW-1:0] camera_z;
    logic [FocalW-1:0] focal;
  } cfg_t;

  function automatic logic signed [CoordW-1:0] sat16(input logic signed [SumW-1:0] v);
    logic signed [SumW-1:0] hi;
    logic signed [SumW-1:0] lo;
    hi = SumW'(32767);
    lo = -SumW'(32768);
    if (v > hi) begin
      return 16'sh7fff;
    end else if (v < lo) begin
      return 16'sh8000;
    end
    return v[CoordW-1:0];
  endfunction

endpackage

// File: hw/rtl/tpp_if.sv
interface tpp_vtx_if;
  logic valid;
  logic ready;
  logic signed [15:0] a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z;
  modport source(output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, input ready);
  modport sink(input valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, output ready);
endinterface

interface tpp_scr_if;
  logic valid;
  logic ready;
  logic signed [15:0] a_sx, a_sy, b_sx, b_sy, c_sx, c_sy;
  logic [2:0] zero_depth;
  modport source(output valid, a_sx, a_sy, b_sx, b_sy, c_sx, c_sy, zero_depth, input ready);
  modport sink(input valid, a_sx, a_sy, b_sx, b_sy, c_sx, c_sy, zero_depth, output ready);
endinterface

// File: hw/rtl/triangle_perspective_project.sv
// Projects one triangle per item to screen space. Each vertex goes through its own lane:
// a multiply stage, a sign stage, one restoring-division stage per quotient bit and an
// output stage, PipeDepth (30) register stages in all. A new item is accepted in every cycle
// while the output stage is empty or its item is taken. The whole pipeline holds when the
// output item is not taken. Configuration writes must happen while the pipeline is empty.
module triangle_perspective_project (
  input logic clk,
  input logic rst,
  tpp_vtx_if.sink vtx,
  tpp_scr_if.source scr,
  input logic cfg_we,
  input logic [tpp_pkg::IndexW-1:0] cfg_index,
  input logic [tpp_pkg::CfgW-1:0] cfg_data
);
  import tpp_pkg::*;

  cfg_t cfg;
  logic [PipeDepth-1:0] vld;
  logic en;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.camera_x <= '0;
      cfg.camera_y <= '0;
      cfg.camera_z <= '0;
      cfg.focal <= FOCAL_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CAMERA_X: cfg.camera_x <= cfg_data;
        REG_CAMERA_Y: cfg.camera_y <= cfg_data;
        REG_CAMERA_Z: cfg.camera_z <= cfg_data;
        REG_FOCAL: cfg.focal <= cfg_data[FocalW-1:0];
        default: ;
      endcase
    end
  end

  assign en = !vld[PipeDepth-1] || scr.ready;
  assign vtx.ready = en;
  assign scr.valid = vld[PipeDepth-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[PipeDepth-2:0], vtx.valid};
    end
  end

  tpp_lane u_lane_a (
    .clk(clk), .en(en), .cfg(cfg), .x(vtx.a_x), .y(vtx.a_y), .z(vtx.a_z),
    .sx(scr.a_sx), .sy(scr.a_sy), .zero(scr.zero_depth[0])
  );
  tpp_lane u_lane_b (
    .clk(clk), .en(en), .cfg(cfg), .x(vtx.b_x), .y(vtx.b_y), .z(vtx.b_z),
    .sx(scr.b_sx), .sy(scr.b_sy), .zero(scr.zero_depth[1])
  );
  tpp_lane u_lane_c (
    .clk(clk), .en(en), .cfg(cfg), .x(vtx.c_x), .y(vtx.c_y), .z(vtx.c_z),
    .sx(scr.c_sx), .sy(scr.c_sy), .zero(scr.zero_depth[2])
  );

  a_reset_focal: assert property (@(posedge clk) rst |=> cfg.focal == FOCAL_RESET)
    else $error("focal length not restored by reset");
  a_enter: assert property (@(posedge clk) disable iff (rst)
    vtx.valid && vtx.ready |=> vld[0])
    else $error("accepted item lost at pipeline entry");
  a_hold: assert property (@(posedge clk) disable iff (rst) !en |=> $stable(vld))
    else $error("pipeline moved while stalled");
  a_zero_a: assert property (@(posedge clk) disable iff (rst)
    scr.valid && scr.zero_depth[0] |-> scr.a_sx == '0 && scr.a_sy == '0)
    else $error("zero depth vertex has nonzero coordinates");

endmodule

// File: hw/rtl/tpp_lane.sv
module tpp_lane (
  input logic clk,
  input logic en,
  input tpp_pkg::cfg_t cfg,
  input logic signed [tpp_pkg::CoordW-1:0] x,
  input logic signed [tpp_pkg::CoordW-1:0] y,
  input logic signed [tpp_pkg::CoordW-1:0] z,
  output logic signed [tpp_pkg::CoordW-1:0] sx,
  output logic signed [tpp_pkg::CoordW-1:0] sy,
  output logic zero
);
  import tpp_pkg::*;

  logic signed [ProdW-1:0] prod_x, prod_y, negp_x, negp_y;
  logic signed [DepthW-1:0] depth, negd;
  logic [DenW-1:0] rem_x [0:NumW];
  logic [DenW-1:0] rem_y [0:NumW];
  logic [NumW-1:0] numr_x [0:NumW];
  logic [NumW-1:0] numr_y [0:NumW];
  logic [DenW-1:0] den [0:NumW];
  logic neg_x [0:NumW];
  logic neg_y [0:NumW];
  logic zer [0:NumW];
  logic signed [QuotW-1:0] q_x, q_y;
  logic signed [SumW-1:0] sum_x, sum_y;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_x <= $signed({1'b0, cfg.focal}) * x;
      prod_y <= $signed({1'b0, cfg.focal}) * y;
      depth <= DepthW'(cfg.camera_z) + DepthW'(z) + DepthW'(cfg.focal);
    end
  end

  assign negp_x = -prod_x;
  assign negp_y = -prod_y;
  assign negd = -depth;

  always_ff @(posedge clk) begin
    if (en) begin
      numr_x[0] <= prod_x[ProdW-1] ? negp_x[NumW-1:0] : prod_x[NumW-1:0];
      numr_y[0] <= prod_y[ProdW-1] ? negp_y[NumW-1:0] : prod_y[NumW-1:0];
      den[0] <= depth[DepthW-1] ? negd[DenW-1:0] : depth[DenW-1:0];
      rem_x[0] <= '0;
      rem_y[0] <= '0;
      neg_x[0] <= prod_x[ProdW-1] ^ depth[DepthW-1];
      neg_y[0] <= prod_y[ProdW-1] ^ depth[DepthW-1];
      zer[0] <= (depth == '0);
    end
  end

  for (genvar i = 0; i < NumW; i++) begin : g_div
    logic [DenW:0] trial_x, trial_y, diff_x, diff_y;
    assign trial_x = {rem_x[i], numr_x[i][NumW-1]};
    assign trial_y = {rem_y[i], numr_y[i][NumW-1]};
    assign diff_x = trial_x - {1'b0, den[i]};
    assign diff_y = trial_y - {1'b0, den[i]};
    always_ff @(posedge clk) begin
      if (en) begin
        rem_x[i+1] <= diff_x[DenW] ? trial_x[DenW-1:0] : diff_x[DenW-1:0];
        rem_y[i+1] <= diff_y[DenW] ? trial_y[DenW-1:0] : diff_y[DenW-1:0];
        numr_x[i+1] <= {numr_x[i][NumW-2:0], ~diff_x[DenW]};
        numr_y[i+1] <= {numr_y[i][NumW-2:0], ~diff_y[DenW]};
        den[i+1] <= den[i];
        neg_x[i+1] <= neg_x[i];
        neg_y[i+1] <= neg_y[i];
        zer[i+1] <= zer[i];
      end
    end
  end

  assign q_x = neg_x[NumW] ? -$signed({1'b0, numr_x[NumW]}) : $signed({1'b0, numr_x[NumW]});
  assign q_y = neg_y[NumW] ? -$signed({1'b0, numr_y[NumW]}) : $signed({1'b0, numr_y[NumW]});
  assign sum_x = SumW'(cfg.camera_x) + SumW'(q_x);
  assign sum_y = SumW'(cfg.camera_y) + SumW'(q_y);

  always_ff @(posedge clk) begin
    if (en) begin
      sx <= zer[NumW] ? '0 : sat16(sum_x);
      sy <= zer[NumW] ? '0 : sat16(sum_y);
      zero <= zer[NumW];
    end
  end

endmodule

// File: sim/triangle_perspective_project_tb.sv
module triangle_perspective_project_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tpp_pkg::*;

  localparam int StallLimit = 5000;
  localparam int DrainCycles = PipeDepth + 10;
  localparam int MaxReports = 10;

  typedef struct {
    logic signed [CoordW-1:0] x[3];
    logic signed [CoordW-1:0] y[3];
    logic signed [CoordW-1:0] z[3];
  } triangle_t;

  typedef struct {
    logic signed [CoordW-1:0] sx[3];
    logic signed [CoordW-1:0] sy[3];
    logic [2:0] zero_depth;
  } screen_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [IndexW-1:0] cfg_index;
  logic [CfgW-1:0] cfg_data;

  tpp_vtx_if vtx ();
  tpp_scr_if scr ();

  triangle_perspective_project uut (
    .clk(clk),
    .rst(rst),
    .vtx(vtx),
    .scr(scr),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  longint cam_x;
  longint cam_y;
  longint cam_z;
  longint focal;

  screen_t screen_queue[$];
  int mismatches;
  int triangles_sent;
  int screens_checked;
  int zero_vertices;
  int settings_used;
  bit idle_on;
  int hold_request;
  int quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic signed [CoordW-1:0] clamp_screen(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[CoordW-1:0];
  endfunction

  function automatic screen_t project_triangle(triangle_t t);
    screen_t s;
    longint depth;
    s.zero_depth = 3'b000;
    for (int v = 0; v < 3; v++) begin
      depth = cam_z + longint'(t.z[v]) + focal;
      if (depth == 0) begin
        s.sx[v] = '0;
        s.sy[v] = '0;
        s.zero_depth[v] = 1'b1;
      end else begin
        s.sx[v] = clamp_screen(cam_x + (focal * longint'(t.x[v])) / depth);
        s.sy[v] = clamp_screen(cam_y + (focal * longint'(t.y[v])) / depth);
      end
    end
    return s;
  endfunction

  task automatic wait_drain();
    while (screen_queue.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  task automatic write_reg(logic [IndexW-1:0] idx, logic [CfgW-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    case (idx)
      REG_CAMERA_X: cam_x = longint'($signed(value));
      REG_CAMERA_Y: cam_y = longint'($signed(value));
      REG_CAMERA_Z: cam_z = longint'($signed(value));
      REG_FOCAL: focal = longint'(value[FocalW-1:0]);
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_camera(int cx, int cy, int cz, int f);
    wait_drain();
    write_reg(REG_CAMERA_X, CfgW'(cx));
    write_reg(REG_CAMERA_Y, CfgW'(cy));
    write_reg(REG_CAMERA_Z, CfgW'(cz));
    write_reg(REG_FOCAL, CfgW'(f));
    settings_used++;
  endtask

  task automatic send_triangle(triangle_t t);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk);
        vtx.valid <= 1'b0;
      end
    end
    @(negedge clk);
    vtx.valid <= 1'b1;
    vtx.a_x <= t.x[0]; vtx.a_y <= t.y[0]; vtx.a_z <= t.z[0];
    vtx.b_x <= t.x[1]; vtx.b_y <= t.y[1]; vtx.b_z <= t.z[1];
    vtx.c_x <= t.x[2]; vtx.c_y <= t.y[2]; vtx.c_z <= t.z[2];
    do @(posedge clk); while (!vtx.ready);
    screen_queue.insert(screen_queue.size(), project_triangle(t));
    triangles_sent++;
  endtask

  task automatic release_input();
    @(negedge clk);
    vtx.valid <= 1'b0;
  endtask

  function automatic triangle_t make_triangle(int cx, int cy, int cz);
    triangle_t t;
    for (int v = 0; v < 3; v++) begin
      t.x[v] = CoordW'(cx);
      t.y[v] = CoordW'(cy);
      t.z[v] = CoordW'(cz);
    end
    return t;
  endfunction

  function automatic triangle_t random_triangle(int zero_chance);
    triangle_t t;
    longint zz;
    for (int v = 0; v < 3; v++) begin
      t.x[v] = CoordW'($urandom());
      t.y[v] = CoordW'($urandom());
      case ($urandom_range(0, 3))
        0: t.z[v] = CoordW'($urandom_range(0, 4000));
        1: t.z[v] = CoordW'($urandom_range(0, 255) - 128);
        default: t.z[v] = CoordW'($urandom());
      endcase
      if ($urandom_range(0, 99) < zero_chance) begin
        zz = -(cam_z + focal);
        if (zz >= -32768 && zz <= 32767) t.z[v] = zz[CoordW-1:0];
      end
      if ($urandom_range(0, 15) == 0) t.x[v] = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
    end
    return t;
  endfunction

  initial begin
    int stall;
    scr.ready = 1'b0;
    stall = 0;
    forever begin
      @(posedge clk);
      if (scr.valid && scr.ready) begin
        screen_t got;
        screen_t want;
        bit bad;
        got.sx[0] = scr.a_sx; got.sy[0] = scr.a_sy;
        got.sx[1] = scr.b_sx; got.sy[1] = scr.b_sy;
        got.sx[2] = scr.c_sx; got.sy[2] = scr.c_sy;
        got.zero_depth = scr.zero_depth;
        if (screen_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= MaxReports) $display("Unexpected item at %0t", $realtime);
        end else begin
          want = screen_queue.pop_front();
          bad = (got.zero_depth !== want.zero_depth);
          for (int v = 0; v < 3; v++)
            if (got.sx[v] !== want.sx[v] || got.sy[v] !== want.sy[v]) bad = 1'b1;
          if (bad) begin
            mismatches++;
            if (mismatches <= MaxReports)
              $display("Mismatch %0d: expected %0d,%0d %0d,%0d %0d,%0d z%b got %0d,%0d %0d,%0d %0d,%0d z%b",
                       screens_checked, want.sx[0], want.sy[0], want.sx[1], want.sy[1],
                       want.sx[2], want.sy[2], want.zero_depth, got.sx[0], got.sy[0],
                       got.sx[1], got.sy[1], got.sx[2], got.sy[2], got.zero_depth);
          end
          zero_vertices += $countones(want.zero_depth);
          screens_checked++;
        end
      end
      @(negedge clk);
      if (hold_request > 0) begin
        stall = hold_request;
        hold_request = 0;
      end else if (stall == 0 && idle_on && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 6);
      end
      if (stall > 0) begin
        scr.ready <= 1'b0;
        stall--;
      end else begin
        scr.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if ((vtx.valid && vtx.ready) || (scr.valid && scr.ready) || rst) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("Timeout after %0d cycles without progress", quiet_cycles);
      $display("triangle_perspective_project test failed");
      $finish;
    end
  end

  task automatic test_reset_config();
    triangle_t t;
    send_triangle(make_triangle(0, 0, 0));
    send_triangle(make_triangle(32767, 32767, 32767));
    send_triangle(make_triangle(-32768, -32768, -32768));
    send_triangle(make_triangle(100, -100, -900));
    send_triangle(make_triangle(5000, -7000, -901));
    send_triangle(make_triangle(-32768, 32767, -899));
    t = make_triangle(1234, -4321, 50);
    t.z[1] = -16'sd900;
    send_triangle(t);
    release_input();
  endtask

  task automatic test_config_extremes();
    set_camera(32767, -32768, 32767, 4095);
    send_triangle(make_triangle(32767, -32768, -32768));
    send_triangle(make_triangle(-32768, 32767, 0));
    send_triangle(make_triangle(1, 1, -32768));
    release_input();
    set_camera(-32768, 32767, -32768, 1);
    send_triangle(make_triangle(32767, 32767, 32767));
    send_triangle(make_triangle(-5, 7, 32767));
    send_triangle(make_triangle(-32768, -32768, -100));
    release_input();
    set_camera(10, -20, 30, 0);
    send_triangle(make_triangle(32767, -32768, -30));
    send_triangle(make_triangle(300, 400, 12));
    send_triangle(make_triangle(-1, -1, -29));
    release_input();
    set_camera(0, 0, -4095, 4095);
    send_triangle(make_triangle(-32768, 32767, 1));
    send_triangle(make_triangle(32767, 32767, -1));
    send_triangle(make_triangle(9, 9, 0));
    release_input();
  endtask

  task automatic test_random_settings(int phases, int per_phase);
    int cz;
    int f;
    for (int p = 0; p < phases; p++) begin
      f = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 4095) : $urandom_range(1, 2000);
      cz = ($urandom_range(0, 1) == 0) ? int'($signed(16'($urandom()))) : $urandom_range(0, 200) - 100;
      set_camera(int'($signed(16'($urandom()))), int'($signed(16'($urandom()))), cz, f);
      idle_on = ($urandom_range(0, 4) != 0);
      for (int i = 0; i < per_phase; i++) send_triangle(random_triangle(8));
      release_input();
    end
    idle_on = 1'b1;
  endtask

  task automatic test_backpressure();
    set_camera(-50, 75, 100, 600);
    hold_request = 300;
    for (int i = 0; i < 120; i++) send_triangle(random_triangle(10));
    release_input();
    wait_drain();
    for (int i = 0; i < 40; i++) send_triangle(random_triangle(10));
    release_input();
    wait_drain();
    for (int i = 0; i < 40; i++) send_triangle(random_triangle(10));
    release_input();
  endtask

  task automatic test_no_idling();
    set_camera(int'($signed(16'($urandom()))), int'($signed(16'($urandom()))), 0, 900);
    idle_on = 1'b0;
    for (int i = 0; i < 300; i++) send_triangle(random_triangle(5));
    release_input();
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    vtx.valid = 1'b0;
    vtx.a_x = '0; vtx.a_y = '0; vtx.a_z = '0;
    vtx.b_x = '0; vtx.b_y = '0; vtx.b_z = '0;
    vtx.c_x = '0; vtx.c_y = '0; vtx.c_z = '0;
    cam_x = 0;
    cam_y = 0;
    cam_z = 0;
    focal = FOCAL_RESET;
    mismatches = 0;
    triangles_sent = 0;
    screens_checked = 0;
    zero_vertices = 0;
    settings_used = 1;
    idle_on = 1'b1;
    hold_request = 0;
    repeat (4) @(negedge clk);
    rst = 1'b0;
    test_reset_config();
    test_config_extremes();
    test_random_settings(12, 120);
    test_backpressure();
    test_no_idling();
    wait_drain();
    $display("Sent %0d triangles over %0d camera settings; checked %0d screen items.",
             triangles_sent, settings_used, screens_checked);
    $display("%0d vertices hit zero depth; %0d mismatches.", zero_vertices, mismatches);
    if (mismatches == 0 && screen_queue.size() == 0) begin
      $display("triangle_perspective_project test passed");
    end else begin
      $display("triangle_perspective_project test failed");
    end
    $finish;
  end

endmodule
